/* rtl/lelc_pkg.sv */
package lelc_pkg;

   // One line of the envelope.
   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
   } line_type;

   // One table entry: the line and the breakpoint with its right neighbor.
   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
      logic signed [32:0] bnum;
      logic [31:0]        bden;
   } entry_type;

   // Request to the dominance test: is l2 still needed between l1 and l3?
   typedef struct packed {
      logic     start;
      line_type l1;
      line_type l2;
      line_type l3;
   } keep_req_type;

   typedef struct packed {
      logic done;
      logic keep;
   } keep_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_DAT,
      ST_CHK,
      ST_CHK_WAIT,
      ST_LP_TEST,
      ST_LP_DAT,
      ST_LP_WAIT,
      ST_RP_START,
      ST_RP_DAT0,
      ST_RP_TEST,
      ST_RP_DAT,
      ST_RP_WAIT,
      ST_SIZE,
      ST_MV_RD,
      ST_MV_WR,
      ST_NEW_WR,
      ST_LEFT_WR,
      ST_Q_RD,
      ST_Q_DAT,
      ST_Q_CMP,
      ST_Q_VAL,
      ST_Q_SUM,
      ST_DONE
   } state_type;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

endpackage

/* rtl/lower_envelope_line_container.sv */
// Lower envelope line container.
// Input beats on the req_ channel either add the line slope*x + intercept
// (func = 0) or ask for the minimum over all stored lines at query_x
// (func = 1). Every input beat yields exactly one beat on the rsp_ channel
// carrying min_value, empty_res, dropped and the line count afterwards.
// The lines sit in one table memory with registered reads, sorted by falling
// slope, each entry holding its breakpoint with the next line.
// An add scans entries to find its slot, tests neighbors for pruning and
// shifts entries to close a gap or open a slot; a query walks entries until
// it reaches the line that holds the minimum. Both are paced by the single
// memory read port that the sequencer walks entry by entry.
// req_stall is low only while the sequencer is idle; a finished beat is held
// in the response register, so the next item is taken while it waits.
// If the receiver holds rsp_stall, the sequencer parks after its next item
// until the response register frees up.
// Reset empties the table at once (the count goes to zero); no clearing
// pass runs, since entries past the count are never read.
module lower_envelope_line_container #(
   parameter int MAX_LINES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic signed [31:0] req_slope,
   input  logic signed [31:0] req_intercept,
   input  logic signed [31:0] req_query_x,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_min_value,
   output logic               rsp_empty_res,
   output logic               rsp_dropped,
   output logic [6:0]         rsp_line_count
);

   localparam int AW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int CW  = $clog2(MAX_LINES + 1);
   localparam int CNW = CW + 1;

   lelc_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] p_ff, p_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] r_ff, r_in;
   logic [CW-1:0] src_ff, src_in;
   logic [CW-1:0] dst_ff, dst_in;
   logic [CW-1:0] newn_ff, newn_in;
   logic          dir_left_ff, dir_left_in;

   lelc_pkg::line_type  newl_ff, newl_in;
   lelc_pkg::line_type  left_ff, left_in;
   lelc_pkg::line_type  right_ff, right_in;
   lelc_pkg::line_type  tmp_ff, tmp_in;
   lelc_pkg::entry_type cur_ff, cur_in;
   logic signed [31:0]  x_ff, x_in;

   logic signed [32:0] mult_b;
   logic signed [65:0] mult_ff;

   logic signed [63:0] res_min_ff, res_min_in;
   logic               res_empty_ff, res_empty_in;
   logic               res_drop_ff, res_drop_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [63:0] rsp_min_ff, rsp_min_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_drop_ff, rsp_drop_in;
   logic [6:0]         rsp_count_ff, rsp_count_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   lelc_pkg::entry_type   wr_data;
   logic [AW-1:0]         rd_addr;
   lelc_pkg::entry_type   rd_data;
   lelc_pkg::line_type    rd_line;
   lelc_pkg::keep_req_type keep_req;
   lelc_pkg::keep_rsp_type keep_rsp;

   logic           accept;
   logic [CNW-1:0] newn_calc;

   assign rd_line.slope     = rd_data.slope;
   assign rd_line.intercept = rd_data.intercept;

   lelc_store #(
      .DEPTH (MAX_LINES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lelc_keep u_keep (
      .clock (clock),
      .reset (reset),
      .req   (keep_req),
      .rsp   (keep_rsp)
   );

   assign req_stall = (state_ff != lelc_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign newn_calc = CNW'(lo_ff) + CNW'(1) + CNW'(count_ff) - CNW'(r_ff);

   // The query multiplier compares x against a breakpoint, then forms slope*x.
   always_comb begin
      if (state_ff == lelc_pkg::ST_Q_DAT) begin
         mult_b = $signed({1'b0, rd_data.bden});
      end else begin
         mult_b = $signed({cur_ff.slope[31], cur_ff.slope});
      end
   end

   always_ff @(posedge clock) begin
      mult_ff <= 66'(x_ff) * 66'(mult_b);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      p_in         = p_ff;
      lo_in        = lo_ff;
      r_in         = r_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      newn_in      = newn_ff;
      dir_left_in  = dir_left_ff;
      newl_in      = newl_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      tmp_in       = tmp_ff;
      cur_in       = cur_ff;
      x_in         = x_ff;
      res_min_in   = res_min_ff;
      res_empty_in = res_empty_ff;
      res_drop_in  = res_drop_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_min_in   = rsp_min_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;
      keep_req     = '0;

      unique case (state_ff)
         lelc_pkg::ST_IDLE: begin
            if (accept) begin
               newl_in.slope     = req_slope;
               newl_in.intercept = req_intercept;
               x_in              = req_query_x;
               res_min_in        = '0;
               res_empty_in      = 1'b0;
               res_drop_in       = 1'b0;
               p_in              = '0;
               if (req_func == lelc_pkg::FUNC_QUERY) begin
                  if (count_ff == '0) begin
                     res_empty_in = 1'b1;
                     state_in     = lelc_pkg::ST_DONE;
                  end else begin
                     state_in = lelc_pkg::ST_Q_RD;
                  end
               end else if (count_ff == '0) begin
                  // First line of an empty table.
                  lo_in    = '0;
                  r_in     = '0;
                  newn_in  = CW'(1);
                  state_in = lelc_pkg::ST_NEW_WR;
               end else begin
                  state_in = lelc_pkg::ST_SCAN_RD;
               end
            end
         end

         lelc_pkg::ST_SCAN_RD: begin
            rd_addr  = p_ff[AW-1:0];
            state_in = lelc_pkg::ST_SCAN_DAT;
         end

         lelc_pkg::ST_SCAN_DAT: begin
            if (rd_data.slope > newl_ff.slope) begin
               left_in = rd_line;
               p_in    = p_ff + CW'(1);
               if (CNW'(p_ff) + CNW'(1) == CNW'(count_ff)) begin
                  state_in = lelc_pkg::ST_CHK;
               end else begin
                  state_in = lelc_pkg::ST_SCAN_RD;
               end
            end else begin
               cur_in   = rd_data;
               state_in = lelc_pkg::ST_CHK;
            end
         end

         lelc_pkg::ST_CHK: begin
            lo_in = p_ff;
            r_in  = p_ff;
            if (p_ff < count_ff && cur_ff.slope == newl_ff.slope) begin
               // Equal slope: only a smaller intercept replaces the entry.
               if (newl_ff.intercept >= cur_ff.intercept) begin
                  state_in = lelc_pkg::ST_DONE;
               end else begin
                  r_in     = p_ff + CW'(1);
                  state_in = lelc_pkg::ST_LP_TEST;
               end
            end else if (p_ff != '0 && p_ff < count_ff) begin
               keep_req.start        = 1'b1;
               keep_req.l1           = left_ff;
               keep_req.l2           = newl_ff;
               keep_req.l3.slope     = cur_ff.slope;
               keep_req.l3.intercept = cur_ff.intercept;
               state_in              = lelc_pkg::ST_CHK_WAIT;
            end else begin
               state_in = lelc_pkg::ST_LP_TEST;
            end
         end

         lelc_pkg::ST_CHK_WAIT: begin
            if (keep_rsp.done) begin
               if (keep_rsp.keep) begin
                  state_in = lelc_pkg::ST_LP_TEST;
               end else begin
                  state_in = lelc_pkg::ST_DONE;
               end
            end
         end

         lelc_pkg::ST_LP_TEST: begin
            if (lo_ff > CW'(1)) begin
               rd_addr  = AW'(lo_ff - CW'(2));
               state_in = lelc_pkg::ST_LP_DAT;
            end else begin
               state_in = lelc_pkg::ST_RP_START;
            end
         end

         lelc_pkg::ST_LP_DAT: begin
            tmp_in         = rd_line;
            keep_req.start = 1'b1;
            keep_req.l1    = rd_line;
            keep_req.l2    = left_ff;
            keep_req.l3    = newl_ff;
            state_in       = lelc_pkg::ST_LP_WAIT;
         end

         lelc_pkg::ST_LP_WAIT: begin
            if (keep_rsp.done) begin
               if (keep_rsp.keep) begin
                  state_in = lelc_pkg::ST_RP_START;
               end else begin
                  lo_in    = lo_ff - CW'(1);
                  left_in  = tmp_ff;
                  state_in = lelc_pkg::ST_LP_TEST;
               end
            end
         end

         lelc_pkg::ST_RP_START: begin
            if (r_ff < count_ff) begin
               rd_addr  = r_ff[AW-1:0];
               state_in = lelc_pkg::ST_RP_DAT0;
            end else begin
               state_in = lelc_pkg::ST_SIZE;
            end
         end

         lelc_pkg::ST_RP_DAT0: begin
            right_in = rd_line;
            state_in = lelc_pkg::ST_RP_TEST;
         end

         lelc_pkg::ST_RP_TEST: begin
            if (CNW'(r_ff) + CNW'(1) < CNW'(count_ff)) begin
               rd_addr  = AW'(r_ff + CW'(1));
               state_in = lelc_pkg::ST_RP_DAT;
            end else begin
               state_in = lelc_pkg::ST_SIZE;
            end
         end

         lelc_pkg::ST_RP_DAT: begin
            tmp_in         = rd_line;
            keep_req.start = 1'b1;
            keep_req.l1    = newl_ff;
            keep_req.l2    = right_ff;
            keep_req.l3    = rd_line;
            state_in       = lelc_pkg::ST_RP_WAIT;
         end

         lelc_pkg::ST_RP_WAIT: begin
            if (keep_rsp.done) begin
               if (keep_rsp.keep) begin
                  state_in = lelc_pkg::ST_SIZE;
               end else begin
                  r_in     = r_ff + CW'(1);
                  right_in = tmp_ff;
                  state_in = lelc_pkg::ST_RP_TEST;
               end
            end
         end

         lelc_pkg::ST_SIZE: begin
            newn_in = CW'(newn_calc);
            if (newn_calc > CNW'(MAX_LINES)) begin
               res_drop_in = 1'b1;
               state_in    = lelc_pkg::ST_DONE;
            end else if (r_ff < count_ff && CNW'(lo_ff) + CNW'(1) < CNW'(r_ff)) begin
               // Lines were pruned: close the gap from the low end up.
               dir_left_in = 1'b1;
               src_in      = r_ff;
               dst_in      = lo_ff + CW'(1);
               state_in    = lelc_pkg::ST_MV_RD;
            end else if (r_ff < count_ff && lo_ff == r_ff) begin
               // Pure insert: open a slot from the high end down.
               dir_left_in = 1'b0;
               src_in      = count_ff - CW'(1);
               dst_in      = count_ff;
               state_in    = lelc_pkg::ST_MV_RD;
            end else begin
               state_in = lelc_pkg::ST_NEW_WR;
            end
         end

         lelc_pkg::ST_MV_RD: begin
            rd_addr  = src_ff[AW-1:0];
            state_in = lelc_pkg::ST_MV_WR;
         end

         lelc_pkg::ST_MV_WR: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff[AW-1:0];
            wr_data = rd_data;
            if (dir_left_ff) begin
               src_in = src_ff + CW'(1);
               dst_in = dst_ff + CW'(1);
               if (CNW'(src_ff) + CNW'(1) == CNW'(count_ff)) begin
                  state_in = lelc_pkg::ST_NEW_WR;
               end else begin
                  state_in = lelc_pkg::ST_MV_RD;
               end
            end else begin
               src_in = src_ff - CW'(1);
               dst_in = dst_ff - CW'(1);
               if (src_ff == r_ff) begin
                  state_in = lelc_pkg::ST_NEW_WR;
               end else begin
                  state_in = lelc_pkg::ST_MV_RD;
               end
            end
         end

         lelc_pkg::ST_NEW_WR: begin
            wr_en             = 1'b1;
            wr_addr           = lo_ff[AW-1:0];
            wr_data.slope     = newl_ff.slope;
            wr_data.intercept = newl_ff.intercept;
            if (r_ff < count_ff) begin
               wr_data.bnum = 33'(right_ff.intercept) - 33'(newl_ff.intercept);
               wr_data.bden = 32'(33'(newl_ff.slope) - 33'(right_ff.slope));
            end else begin
               wr_data.bnum = '0;
               wr_data.bden = 32'd1;
            end
            count_in = newn_ff;
            if (lo_ff != '0) begin
               state_in = lelc_pkg::ST_LEFT_WR;
            end else begin
               state_in = lelc_pkg::ST_DONE;
            end
         end

         lelc_pkg::ST_LEFT_WR: begin
            wr_en             = 1'b1;
            wr_addr           = AW'(lo_ff - CW'(1));
            wr_data.slope     = left_ff.slope;
            wr_data.intercept = left_ff.intercept;
            wr_data.bnum      = 33'(newl_ff.intercept) - 33'(left_ff.intercept);
            wr_data.bden      = 32'(33'(left_ff.slope) - 33'(newl_ff.slope));
            state_in          = lelc_pkg::ST_DONE;
         end

         lelc_pkg::ST_Q_RD: begin
            rd_addr  = p_ff[AW-1:0];
            state_in = lelc_pkg::ST_Q_DAT;
         end

         lelc_pkg::ST_Q_DAT: begin
            cur_in = rd_data;
            if (CNW'(p_ff) + CNW'(1) < CNW'(count_ff)) begin
               state_in = lelc_pkg::ST_Q_CMP;
            end else begin
               state_in = lelc_pkg::ST_Q_VAL;
            end
         end

         lelc_pkg::ST_Q_CMP: begin
            if (66'(cur_ff.bnum) < mult_ff) begin
               p_in     = p_ff + CW'(1);
               state_in = lelc_pkg::ST_Q_RD;
            end else begin
               state_in = lelc_pkg::ST_Q_VAL;
            end
         end

         lelc_pkg::ST_Q_VAL: begin
            state_in = lelc_pkg::ST_Q_SUM;
         end

         lelc_pkg::ST_Q_SUM: begin
            res_min_in = mult_ff[63:0] + 64'(cur_ff.intercept);
            state_in   = lelc_pkg::ST_DONE;
         end

         lelc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = res_min_ff;
               rsp_empty_in = res_empty_ff;
               rsp_drop_in  = res_drop_ff;
               rsp_count_in = 7'(count_ff);
               state_in     = lelc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lelc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lelc_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      lo_ff        <= lo_in;
      r_ff         <= r_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      newn_ff      <= newn_in;
      dir_left_ff  <= dir_left_in;
      newl_ff      <= newl_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      tmp_ff       <= tmp_in;
      cur_ff       <= cur_in;
      x_ff         <= x_in;
      res_min_ff   <= res_min_in;
      res_empty_ff <= res_empty_in;
      res_drop_ff  <= res_drop_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_min_value  = rsp_min_ff;
   assign rsp_empty_res  = rsp_empty_ff;
   assign rsp_dropped    = rsp_drop_ff;
   assign rsp_line_count = rsp_count_ff;

   // The table never holds more lines than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CNW'(count_ff) <= CNW'(MAX_LINES))
      else $error("line count exceeds capacity");

   // Queries never write the table.
   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lelc_pkg::ST_Q_RD || state_ff == lelc_pkg::ST_Q_DAT ||
       state_ff == lelc_pkg::ST_Q_CMP || state_ff == lelc_pkg::ST_Q_VAL ||
       state_ff == lelc_pkg::ST_Q_SUM) |-> !wr_en)
      else $error("table written during a query");

   // The count moves only when the new line is written.
   a_count_update: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(count_ff) |-> $past(state_ff == lelc_pkg::ST_NEW_WR))
      else $error("line count changed outside the commit step");

   // Test results arrive only while the sequencer waits for them.
   a_keep_wait: assert property (@(posedge clock) disable iff (reset)
      keep_rsp.done |-> (state_ff == lelc_pkg::ST_CHK_WAIT ||
                         state_ff == lelc_pkg::ST_LP_WAIT ||
                         state_ff == lelc_pkg::ST_RP_WAIT))
      else $error("dominance result with no test pending");

   // A new response beat is loaded only from the completion step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(state_ff == lelc_pkg::ST_DONE))
      else $error("response raised outside completion");

endmodule

/* rtl/lelc_store.sv */
module lelc_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  lelc_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output lelc_pkg::entry_type rd_data
);

   lelc_pkg::entry_type mem [DEPTH];
   lelc_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data is registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lelc_keep.sv */
module lelc_keep (
   input  logic                   clock,
   input  logic                   reset,
   input  lelc_pkg::keep_req_type req,
   output lelc_pkg::keep_rsp_type rsp
);

   // The middle line stays when (b3-b2)*(a1-a2) > (b2-b1)*(a2-a3), exactly.
   logic signed [32:0] d1_ff, m1_ff, d2_ff, m2_ff;
   logic signed [65:0] p1_ff, p2_ff;
   logic               v1_ff, v2_ff;

   always_ff @(posedge clock) begin
      d1_ff <= 33'(req.l3.intercept) - 33'(req.l2.intercept);
      m1_ff <= 33'(req.l1.slope) - 33'(req.l2.slope);
      d2_ff <= 33'(req.l2.intercept) - 33'(req.l1.intercept);
      m2_ff <= 33'(req.l2.slope) - 33'(req.l3.slope);
      p1_ff <= 66'(d1_ff) * 66'(m1_ff);
      p2_ff <= 66'(d2_ff) * 66'(m2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= req.start;
         v2_ff <= v1_ff;
      end
   end

   assign rsp.done = v2_ff;
   assign rsp.keep = (p1_ff > p2_ff);

endmodule
